>>> sv/cihe_pkg.sv
// Shared types and constants of the CBOR item head encoder.
package cihe_pkg;

   // Command codes carried on req_cmd
   typedef enum logic [2:0] {
      CMD_INT   = 3'd0,
      CMD_TSTR  = 3'd1,
      CMD_BSTR  = 3'd2,
      CMD_ARRAY = 3'd3,
      CMD_MAP   = 3'd4,
      CMD_RAW   = 3'd5
   } cmd_type;

   // Major type bits of the initial byte
   localparam logic [7:0] MAJOR_UINT = 8'h00;
   localparam logic [7:0] MAJOR_NINT = 8'h20;
   localparam logic [7:0] MAJOR_BSTR = 8'h40;
   localparam logic [7:0] MAJOR_TSTR = 8'h60;
   localparam logic [7:0] MAJOR_LIST = 8'h80;
   localparam logic [7:0] MAJOR_MAP  = 8'ha0;

   // Additional-info codes and the immediate limit
   localparam logic [4:0] MAX_IMMEDIATE = 5'd23;
   localparam logic [7:0] AI_ONE        = 8'd24;
   localparam logic [7:0] AI_TWO        = 8'd25;
   localparam logic [7:0] AI_FOUR       = 8'd26;
   localparam logic [7:0] AI_EIGHT      = 8'd27;

   localparam logic [15:0] CAPACITY_RESET = 16'd4096;

   // One classified request: initial byte, argument bytes left-aligned, their count
   typedef struct packed {
      logic [7:0]  head_byte;
      logic [63:0] arg;
      logic [3:0]  arg_bytes;
   } desc_type;

   // Back end status seen by the top level
   typedef struct packed {
      logic overflowed;
   } back_status_type;

endpackage

>>> sv/cihe_front.sv
// Front end: classifies a request into an initial byte and argument bytes.
module cihe_front (
   input  logic [2:0]         req_cmd,
   input  logic signed [63:0] req_value,
   output logic               desc_known,
   output cihe_pkg::desc_type desc
);

   logic [7:0]  major;
   logic [63:0] n;
   logic        raw;

   always_comb begin
      major      = cihe_pkg::MAJOR_UINT;
      n          = req_value;
      raw        = 1'b0;
      desc_known = 1'b1;
      case (req_cmd)
         cihe_pkg::CMD_INT: begin
            if (req_value[63]) begin
               major = cihe_pkg::MAJOR_NINT;
               n     = ~req_value;
            end
         end
         cihe_pkg::CMD_TSTR:  major = cihe_pkg::MAJOR_TSTR;
         cihe_pkg::CMD_BSTR:  major = cihe_pkg::MAJOR_BSTR;
         cihe_pkg::CMD_ARRAY: major = cihe_pkg::MAJOR_LIST;
         cihe_pkg::CMD_MAP:   major = cihe_pkg::MAJOR_MAP;
         cihe_pkg::CMD_RAW:   raw = 1'b1;
         default:             desc_known = 1'b0;
      endcase
   end

   // Pick the shortest head; argument bytes go out most significant first
   always_comb begin
      desc.arg       = 64'd0;
      desc.arg_bytes = 4'd0;
      if (raw) begin
         desc.head_byte = req_value[7:0];
      end else if ((n[63:5] == 59'd0) && (n[4:0] <= cihe_pkg::MAX_IMMEDIATE)) begin
         desc.head_byte = major | {3'b000, n[4:0]};
      end else if (|n[63:32]) begin
         desc.head_byte = major | cihe_pkg::AI_EIGHT;
         desc.arg       = n;
         desc.arg_bytes = 4'd8;
      end else if (|n[31:16]) begin
         desc.head_byte = major | cihe_pkg::AI_FOUR;
         desc.arg       = {n[31:0], 32'd0};
         desc.arg_bytes = 4'd4;
      end else if (|n[15:8]) begin
         desc.head_byte = major | cihe_pkg::AI_TWO;
         desc.arg       = {n[15:0], 48'd0};
         desc.arg_bytes = 4'd2;
      end else begin
         desc.head_byte = major | cihe_pkg::AI_ONE;
         desc.arg       = {n[7:0], 56'd0};
         desc.arg_bytes = 4'd1;
      end
   end

endmodule

>>> sv/cihe_queue.sv
// Short FIFO of classified requests between front and back end.
module cihe_queue #(
   parameter int DEPTH = 4
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  cihe_pkg::desc_type push_data,
   input  logic               pop,
   output cihe_pkg::desc_type pop_data,
   output logic               full,
   output logic               empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   cihe_pkg::desc_type entry_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;

   assign full     = (count_ff == CNT_W'(DEPTH));
   assign empty    = (count_ff == '0);
   assign pop_data = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

>>> sv/cihe_back.sv
// Back end: serialises heads a byte per cycle when not stalled; tracks buffer position and overflow.
module cihe_back (
   input  logic                      clock,
   input  logic                      reset,
   input  logic [15:0]               capacity,
   input  cihe_pkg::desc_type        q_data,
   input  logic                      q_empty,
   output logic                      q_pop,
   output cihe_pkg::back_status_type status,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic [7:0]                rsp_out_byte,
   output logic [15:0]               rsp_offset,
   output logic                      rsp_written,
   output logic                      rsp_last
);

   logic [3:0]  remain_ff, remain_in;
   logic [63:0] shift_ff, shift_in;
   logic [15:0] pos_ff, pos_in;
   logic        ovf_ff, ovf_in;
   logic        valid_ff, valid_in;
   logic [7:0]  byte_ff, byte_in;
   logic [15:0] offset_ff, offset_in;
   logic        written_ff, written_in;
   logic        last_ff, last_in;
   logic        step;
   logic        from_queue;
   logic        fits;

   assign from_queue = (remain_ff == 4'd0);
   // Advance when the output register is free or being taken and a byte is available
   assign step  = (!valid_ff || rsp_ready) && (!from_queue || !q_empty);
   assign q_pop = step && from_queue;
   assign fits  = !ovf_ff && (pos_ff < capacity);

   always_comb begin
      remain_in  = remain_ff;
      shift_in   = shift_ff;
      pos_in     = pos_ff;
      ovf_in     = ovf_ff;
      valid_in   = valid_ff && !rsp_ready;
      byte_in    = byte_ff;
      offset_in  = offset_ff;
      written_in = written_ff;
      last_in    = last_ff;
      if (step) begin
         valid_in = 1'b1;
         if (from_queue) begin
            byte_in   = q_data.head_byte;
            remain_in = q_data.arg_bytes;
            shift_in  = q_data.arg;
         end else begin
            byte_in   = shift_ff[63:56];
            remain_in = remain_ff - 4'd1;
            shift_in  = {shift_ff[55:0], 8'd0};
         end
         last_in = (remain_in == 4'd0);
         if (fits) begin
            offset_in  = pos_ff;
            written_in = 1'b1;
            pos_in     = pos_ff + 16'd1;
         end else begin
            // Drop the byte; overflow stays set until reset
            offset_in  = 16'd0;
            written_in = 1'b0;
            ovf_in     = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         remain_ff <= 4'd0;
         pos_ff    <= 16'd0;
         ovf_ff    <= 1'b0;
         valid_ff  <= 1'b0;
      end else begin
         remain_ff <= remain_in;
         pos_ff    <= pos_in;
         ovf_ff    <= ovf_in;
         valid_ff  <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      shift_ff   <= shift_in;
      byte_ff    <= byte_in;
      offset_ff  <= offset_in;
      written_ff <= written_in;
      last_ff    <= last_in;
   end

   assign status.overflowed = ovf_ff;

   assign rsp_valid    = valid_ff;
   assign rsp_out_byte = byte_ff;
   assign rsp_offset   = offset_ff;
   assign rsp_written  = written_ff;
   assign rsp_last     = last_ff;

endmodule

>>> sv/cbor_item_head_encoder_core.sv
// Top level of the CBOR item head encoder: capacity register, front end, queue, back end.
//
// Each request (integer, string, array or map head, or raw byte) becomes the bytes of one
// shortest-form CBOR head, or one raw byte, delivered one byte per rsp handshake in output
// order, with last set on the final byte of the request. The back end emits one byte per
// cycle, unless rsp_ready holds it, through a single output register; a raw byte or an
// immediate head is one byte, and a head with an argument is the initial byte followed by
// n = 1, 2, 4 or 8 argument bytes. A request is taken whenever the request queue
// (QUEUE_DEPTH entries) has room, so requests may arrive back to back while earlier heads
// are still being sent; the first byte of a request enters the output register as the
// request is popped from the queue. Each byte is stored at the write position while that
// position is below the capacity; the first byte that does not fit sets a sticky overflow,
// after which every byte reports written low and offset zero until reset. Command codes 6
// and 7 are taken and dropped. Write the capacity only while no request is in flight.
module cbor_item_head_encoder_core #(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [2:0]         req_cmd,
   input  logic signed [63:0] req_value,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [7:0]         rsp_out_byte,
   output logic [15:0]        rsp_offset,
   output logic               rsp_written,
   output logic               rsp_last,
   input  logic               csr_write_enable,
   input  logic [15:0]        csr_write_data
);

   logic [15:0]               capacity_ff;
   logic                      desc_known;
   cihe_pkg::desc_type        front_desc;
   cihe_pkg::desc_type        q_data;
   logic                      q_push;
   logic                      q_pop;
   logic                      q_full;
   logic                      q_empty;
   cihe_pkg::back_status_type back_status;

   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff <= cihe_pkg::CAPACITY_RESET;
      end else if (csr_write_enable) begin
         capacity_ff <= csr_write_data;
      end
   end

   assign req_ready = !q_full;
   assign q_push    = req_valid && req_ready && desc_known;

   cihe_front u_front (
      .req_cmd    (req_cmd),
      .req_value  (req_value),
      .desc_known (desc_known),
      .desc       (front_desc)
   );

   cihe_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (front_desc),
      .pop       (q_pop),
      .pop_data  (q_data),
      .full      (q_full),
      .empty     (q_empty)
   );

   cihe_back u_back (
      .clock        (clock),
      .reset        (reset),
      .capacity     (capacity_ff),
      .q_data       (q_data),
      .q_empty      (q_empty),
      .q_pop        (q_pop),
      .status       (back_status),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_out_byte (rsp_out_byte),
      .rsp_offset   (rsp_offset),
      .rsp_written  (rsp_written),
      .rsp_last     (rsp_last)
   );

`ifndef NO_ASSERTIONS
   overflow_sticky_a: assert property (@(posedge clock) disable iff (reset)
      back_status.overflowed |=> back_status.overflowed)
      else $error("overflow flag cleared without reset");

   dropped_offset_a: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_written) |-> (rsp_offset == 16'd0))
      else $error("dropped byte carries a nonzero offset");

   stored_in_range_a: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_written) |-> (rsp_offset < capacity_ff))
      else $error("stored byte beyond capacity");

   pop_nonempty_a: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> !q_empty)
      else $error("request queue popped while empty");
`endif

endmodule
